>>> sv/cdq_pkg.sv
package cdq_pkg;

    // Deque geometry
    localparam int DEPTH      = 8;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Fixed field widths
    localparam int ACT_W = 3;
    localparam int VAL_W = 32;
    localparam int STS_W = 2;
    localparam int OCC_W = 4;

    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [DATA_WIDTH-1:0] t_word;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_REAR  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_REAR   = 3'd3,
        ACT_PEEK_FRONT = 3'd4,
        ACT_PEEK_REAR  = 3'd5
    } t_action;

    typedef enum logic [STS_W-1:0] {
        STS_DONE  = 2'd0,
        STS_FULL  = 2'd1,
        STS_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        ST_IDLE,
        ST_RESULT
    } t_state;

    // Store port controls from the sequencer
    typedef struct packed {
        logic  wr_en;
        t_idx  wr_addr;
        logic  rd_en;
        t_idx  rd_addr;
    } t_store_ctl;

    // Circular index steps
    function automatic t_idx idx_up(input t_idx i);
        return (i == t_idx'(DEPTH - 1)) ? '0 : i + t_idx'(1);
    endfunction

    function automatic t_idx idx_down(input t_idx i);
        return (i == '0) ? t_idx'(DEPTH - 1) : i - t_idx'(1);
    endfunction

endpackage

>>> sv/cdq_if.sv
// Request channel
interface cdq_req_if;
    import cdq_pkg::*;
    logic             valid;
    logic             ready;
    logic [ACT_W-1:0] action;
    logic [VAL_W-1:0] push_value;

    modport source (output valid, output action, output push_value, input ready);
    modport sink   (input valid, input action, input push_value, output ready);
endinterface

// Result channel
interface cdq_res_if;
    import cdq_pkg::*;
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] read_value;
    logic [STS_W-1:0] status;
    logic [OCC_W-1:0] occupancy;

    modport source (output valid, output read_value, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input read_value, input status, input occupancy,
                    output ready);
endinterface

>>> sv/cdq_store.sv
module cdq_store (
    input  logic                i_clk,
    input  cdq_pkg::t_store_ctl i_ctl,
    input  cdq_pkg::t_word      i_wr_data,
    output cdq_pkg::t_word      o_rd_data
);
    import cdq_pkg::*;

    t_word r_mem [DEPTH];
    t_word r_rd_data;

    // Single write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_ctl.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> sv/circular_deque_top.sv
// Channel | Dir | Payload                              | Handshake
// i_req   | in  | action, push_value                   | valid/ready
// o_res   | out | read_value, status, occupancy        | valid/ready
//
// A request is accepted in the idle state, where indices and count are updated and
// the store write or read is issued; the result state then collects the store
// read data, since the read port of the entry store is registered.
// Reset clears indices, count, state and the result valid; entries stay unset.
// A result held in the output register does not block the next request;
// a stalled result only holds the sequencer in its result state.
module circular_deque_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cdq_req_if.sink       i_req,
    cdq_res_if.source     o_res
);
    import cdq_pkg::*;

    t_state     r_state, n_state;
    t_idx       r_head, n_head;
    t_idx       r_tail, n_tail;
    t_cnt       r_count, n_count;
    t_status    r_status, n_status;
    logic       r_use_rd, n_use_rd;
    t_store_ctl s_ctl;
    t_word      s_wr_data;
    t_word      s_rd_data;

    logic             r_out_valid, n_out_valid;
    logic [VAL_W-1:0] r_read_value;
    t_status          r_out_status;
    logic [OCC_W-1:0] r_occ;

    logic             s_accept;
    logic             s_load;
    logic [63:0]      s_push_ext;
    logic [63:0]      s_rd_ext;

    assign s_accept   = i_req.valid && i_req.ready;
    assign s_load     = (r_state == ST_RESULT) && (!r_out_valid || o_res.ready);
    assign s_push_ext = 64'(i_req.push_value);
    assign s_wr_data  = s_push_ext[DATA_WIDTH-1:0];
    assign s_rd_ext   = 64'(s_rd_data);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (s_accept) n_state = ST_RESULT;
            ST_RESULT: if (s_load)   n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        i_req.ready = (r_state == ST_IDLE);
    end

    // Request decode: index, count and store control
    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_status = r_status;
        n_use_rd = r_use_rd;
        s_ctl    = '0;
        if (s_accept) begin
            n_status = STS_DONE;
            n_use_rd = 1'b0;
            unique case (i_req.action)
                ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
                    if (r_count == t_cnt'(DEPTH)) begin
                        n_status = STS_FULL;
                    end else begin
                        s_ctl.wr_en = 1'b1;
                        if (r_count == '0) begin
                            n_head        = '0;
                            n_tail        = '0;
                            s_ctl.wr_addr = '0;
                        end else if (i_req.action == ACT_PUSH_FRONT) begin
                            n_head        = idx_down(r_head);
                            s_ctl.wr_addr = n_head;
                        end else begin
                            n_tail        = idx_up(r_tail);
                            s_ctl.wr_addr = n_tail;
                        end
                        n_count = r_count + t_cnt'(1);
                    end
                end
                ACT_POP_FRONT, ACT_POP_REAR, ACT_PEEK_FRONT, ACT_PEEK_REAR: begin
                    if (r_count == '0) begin
                        n_status = STS_EMPTY;
                    end else begin
                        n_use_rd      = 1'b1;
                        s_ctl.rd_en   = 1'b1;
                        s_ctl.rd_addr = (i_req.action == ACT_POP_FRONT ||
                                         i_req.action == ACT_PEEK_FRONT) ? r_head : r_tail;
                        if (i_req.action == ACT_POP_FRONT ||
                            i_req.action == ACT_POP_REAR) begin
                            if (r_count == t_cnt'(1)) begin
                                n_head = '0;
                                n_tail = '0;
                            end else if (i_req.action == ACT_POP_FRONT) begin
                                n_head = idx_up(r_head);
                            end else begin
                                n_tail = idx_down(r_tail);
                            end
                            n_count = r_count - t_cnt'(1);
                        end
                    end
                end
                default: ;  // unused action codes leave indices, count and store alone
            endcase
        end
    end

    // Output register fill and drain
    always_comb begin
        n_out_valid = r_out_valid;
        if (s_load) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Request and result payload
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_use_rd <= n_use_rd;
        if (s_load) begin
            r_read_value <= r_use_rd ? s_rd_ext[VAL_W-1:0] : '0;
            r_out_status <= r_status;
            r_occ        <= OCC_W'(r_count);
        end
    end

    cdq_store u_store (
        .i_clk     (i_clk),
        .i_ctl     (s_ctl),
        .i_wr_data (s_wr_data),
        .o_rd_data (s_rd_data)
    );

    assign o_res.valid      = r_out_valid;
    assign o_res.read_value = r_read_value;
    assign o_res.status     = r_out_status;
    assign o_res.occupancy  = r_occ;

endmodule

>>> sv/cdq_checker.sv
module cdq_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_req_valid,
    input logic                      i_req_ready,
    input logic                      i_res_valid,
    input logic                      i_res_ready,
    input logic [cdq_pkg::VAL_W-1:0] i_res_read_value,
    input logic [cdq_pkg::STS_W-1:0] i_res_status,
    input logic [cdq_pkg::OCC_W-1:0] i_res_occupancy
);
    import cdq_pkg::*;

    // One request in flight: no accept on the cycle after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request accepted while previous still in work");

    // Refused push only when full
    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res_status == STS_FULL) |-> i_res_occupancy == OCC_W'(DEPTH))
        else $error("full status with occupancy below depth");

    // Refused pop or peek only when empty, and reads back zero
    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res_status == STS_EMPTY) |->
            (i_res_occupancy == '0 && i_res_read_value == '0))
        else $error("empty status with words stored or non-zero value");

    // Stalled result holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=>
            (i_res_valid && $stable(i_res_read_value) && $stable(i_res_status) &&
             $stable(i_res_occupancy)))
        else $error("result changed while stalled");

endmodule

bind circular_deque_top cdq_checker u_cdq_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_valid      (i_req.valid),
    .i_req_ready      (i_req.ready),
    .i_res_valid      (o_res.valid),
    .i_res_ready      (o_res.ready),
    .i_res_read_value (o_res.read_value),
    .i_res_status     (o_res.status),
    .i_res_occupancy  (o_res.occupancy)
);

>>> tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cdq_pkg::*;

    // Action codes outside the defined set; the block must ignore them
    localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

    localparam int RANDOM_REQS  = 1200;
    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 160;

    typedef struct {
        logic [ACT_W-1:0] action;
        logic [VAL_W-1:0] push_value;
    } t_deque_req;

    typedef struct {
        logic [VAL_W-1:0] read_value;
        logic [STS_W-1:0] status;
        logic [OCC_W-1:0] occupancy;
    } t_deque_res;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cdq_req_if req_ch();
    cdq_res_if res_ch();

    circular_deque_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    // Requests waiting to be driven, results waiting to be seen
    t_deque_req pending_reqs[$];
    t_deque_res awaited_results[$];

    // Shadow deque
    t_word deque_words[DEPTH];
    int    front_idx  = 0;
    int    rear_idx   = 0;
    int    word_count = 0;

    int total_reqs     = 0;
    int accepted_reqs  = 0;
    int results_seen   = 0;
    int error_count    = 0;
    int cycle_count    = 0;
    int burst_left     = 0;
    int gap_left       = 0;
    int hold_left      = 0;
    int next_hold_at   = 150;
    int stall_mode     = 0;
    int mode_left      = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Work out the result of one accepted request and update the shadow deque
    function automatic t_deque_res deque_apply(input t_deque_req r);
        t_deque_res res;
        t_word      w;
        logic       at_front;
        res.read_value = '0;
        res.status     = STS_DONE;
        w              = r.push_value[DATA_WIDTH-1:0];
        case (r.action)
            ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
                if (word_count >= DEPTH) begin
                    res.status = STS_FULL;
                end else begin
                    if (word_count == 0) begin
                        front_idx      = 0;
                        rear_idx       = 0;
                        deque_words[0] = w;
                    end else if (r.action == ACT_PUSH_FRONT) begin
                        front_idx              = (front_idx + DEPTH - 1) % DEPTH;
                        deque_words[front_idx] = w;
                    end else begin
                        rear_idx              = (rear_idx + 1) % DEPTH;
                        deque_words[rear_idx] = w;
                    end
                    word_count++;
                end
            end
            ACT_POP_FRONT, ACT_POP_REAR, ACT_PEEK_FRONT, ACT_PEEK_REAR: begin
                if (word_count == 0) begin
                    res.status = STS_EMPTY;
                end else begin
                    at_front = (r.action == ACT_POP_FRONT) || (r.action == ACT_PEEK_FRONT);
                    res.read_value = VAL_W'(deque_words[at_front ? front_idx : rear_idx]);
                    if (r.action == ACT_POP_FRONT || r.action == ACT_POP_REAR) begin
                        // last word out: both indices return to zero
                        if (word_count == 1) begin
                            front_idx = 0;
                            rear_idx  = 0;
                        end else if (at_front) begin
                            front_idx = (front_idx + 1) % DEPTH;
                        end else begin
                            rear_idx = (rear_idx + DEPTH - 1) % DEPTH;
                        end
                        word_count--;
                    end
                end
            end
            default: ;
        endcase
        res.occupancy = OCC_W'(word_count);
        return res;
    endfunction

    task automatic queue_req(input logic [ACT_W-1:0] act, input logic [VAL_W-1:0] val);
        t_deque_req r;
        r.action     = act;
        r.push_value = val;
        pending_reqs.push_back(r);
        total_reqs++;
    endtask

    // Data word with a bias towards the corners of the range
    function automatic logic [VAL_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return 32'h8000_0000;
            3:       return 32'h7fff_ffff;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    // Request driver: bursts of random length with random gaps
    always @(posedge i_clk) begin
        t_deque_req taken;
        t_deque_req nxt;
        logic       offer;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                taken.action     = req_ch.action;
                taken.push_value = req_ch.push_value;
                awaited_results.push_back(deque_apply(taken));
                accepted_reqs++;
            end
            // a request still on offer is held until taken
            if (!req_ch.valid || req_ch.ready) begin
                offer = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_reqs.size() > 0) begin
                    nxt                = pending_reqs.pop_front();
                    offer              = 1'b1;
                    req_ch.action     <= nxt.action;
                    req_ch.push_value <= nxt.push_value;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
                    end else begin
                        burst_left--;
                    end
                end
                req_ch.valid <= offer;
            end
        end
    end

    // Result monitor and receiver stall pattern
    always @(posedge i_clk) begin
        t_deque_res want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                results_seen++;
                if (awaited_results.size() == 0) begin
                    $error("result with nothing outstanding: read_value %0h status %0d occ %0d",
                           res_ch.read_value, res_ch.status, res_ch.occupancy);
                    error_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (res_ch.read_value !== want.read_value) begin
                        $error("read_value: expected %0h, got %0h",
                               want.read_value, res_ch.read_value);
                        error_count++;
                    end
                    if (res_ch.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, res_ch.status);
                        error_count++;
                    end
                    if (res_ch.occupancy !== want.occupancy) begin
                        $error("occupancy: expected %0d, got %0d",
                               want.occupancy, res_ch.occupancy);
                        error_count++;
                    end
                end
            end
            // long hold-off now and then so the block backs up onto its input
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else if (results_seen >= next_hold_at) begin
                hold_left     = HOLD_CYCLES;
                next_hold_at += 450;
                res_ch.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(8, 60);
                end else begin
                    mode_left--;
                end
                case (stall_mode)
                    0, 1:    res_ch.ready <= 1'b1;
                    2:       res_ch.ready <= ($urandom_range(0, 3) != 0);
                    default: res_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int         work_reqs;
        int         seg_len;
        int         push_pct;
        int         roll;
        logic [2:0] pick;
        req_ch.valid      = 1'b0;
        req_ch.action     = '0;
        req_ch.push_value = '0;
        res_ch.ready      = 1'b0;
        i_rst_n           = 1'b0;

        // Directed: empty refusals, corner words, last-word pop, wrap, full refusals
        queue_req(ACT_POP_FRONT,  '0);
        queue_req(ACT_POP_REAR,   '1);
        queue_req(ACT_PEEK_FRONT, '0);
        queue_req(ACT_PEEK_REAR,  '1);
        queue_req(ACT_PUSH_FRONT, 32'h7fff_ffff);
        queue_req(ACT_PUSH_REAR,  32'h8000_0000);
        queue_req(ACT_PEEK_FRONT, '0);
        queue_req(ACT_PEEK_REAR,  '0);
        queue_req(ACT_POP_REAR,   '0);
        queue_req(ACT_POP_FRONT,  '0);
        queue_req(ACT_SPARE_LO,   '1);
        queue_req(ACT_PUSH_FRONT, '0);
        queue_req(ACT_PUSH_FRONT, '1);
        queue_req(ACT_PUSH_FRONT, 32'h5555_5555);
        queue_req(ACT_PUSH_FRONT, 32'haaaa_aaaa);
        queue_req(ACT_PUSH_REAR,  32'h0000_0001);
        queue_req(ACT_PUSH_REAR,  32'hfffe_0000);
        queue_req(ACT_PUSH_REAR,  32'h1234_5678);
        queue_req(ACT_PUSH_REAR,  32'hdead_beef);
        queue_req(ACT_PUSH_FRONT, 32'h0bad_f00d);
        queue_req(ACT_PUSH_REAR,  32'hcafe_0001);
        queue_req(ACT_SPARE_HI,   '0);
        queue_req(ACT_PEEK_REAR,  '0);
        queue_req(ACT_POP_FRONT,  '0);
        queue_req(ACT_POP_REAR,   '0);

        // Random: segments that lean towards filling, balance or draining
        work_reqs = 0;
        while (work_reqs < RANDOM_REQS) begin
            seg_len = $urandom_range(6, 40);
            case ($urandom_range(0, 2))
                0:       push_pct = 75;
                1:       push_pct = 45;
                default: push_pct = 20;
            endcase
            repeat (seg_len) begin
                roll = $urandom_range(0, 99);
                if (roll < 3) begin
                    queue_req($urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO, pick_word());
                end else begin
                    roll = $urandom_range(0, 99);
                    if (roll < push_pct) begin
                        pick = $urandom_range(0, 1) ? ACT_PUSH_REAR : ACT_PUSH_FRONT;
                    end else begin
                        case ($urandom_range(0, 9))
                            0, 1, 2, 3: pick = ACT_POP_FRONT;
                            4, 5, 6:    pick = ACT_POP_REAR;
                            7, 8:       pick = ACT_PEEK_FRONT;
                            default:    pick = ACT_PEEK_REAR;
                        endcase
                    end
                    queue_req(pick, pick_word());
                    work_reqs++;
                end
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every request to go in and every result to come out
        while (accepted_reqs < total_reqs || awaited_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/cdq_pkg.sv
sv/cdq_if.sv
sv/cdq_store.sv
sv/circular_deque_top.sv
sv/cdq_checker.sv
tb/tb_top.sv
